>>> design/huffman_code_builder_unit_macros.svh
// Assertion macros for the Huffman code builder.
`ifndef HUFFMAN_CODE_BUILDER_UNIT_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HCB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HCB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HCB_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define HCB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> design/hcb_pkg.sv
// Shared types and constants of the Huffman code builder.
package hcb_pkg;
  localparam int SYM_N = 256;
  localparam int SYM_W = 8;
  localparam int CNT_W = 32;
  localparam int WGT_W = 40;
  localparam int LEN_W = 7;
  localparam int MAX_LEN = 64;
  localparam int WORD_W = 64;
  localparam int DIST_W = 9;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_BLD = 2'd1,
    OP_QRY = 2'd2,
    OP_CLR = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] sym;
  } req_t;

  typedef enum logic [1:0] {
    SORT_NOP,
    SORT_CLR,
    SORT_INS,
    SORT_POP2
  } sort_op_t;

  typedef struct packed {
    sort_op_t         op;
    logic [SYM_W-1:0] id;
    logic [WGT_W-1:0] w;
  } sort_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_QRY_RSP,
    ST_LOAD,
    ST_CHECK,
    ST_POP,
    ST_SWEEP,
    ST_INS,
    ST_FINISH
  } state_t;
endpackage

>>> design/hcb_front.sv
// Request queue that accepts and classifies incoming beats.
module hcb_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                req_type,
  input  logic [hcb_pkg::SYM_W-1:0] byte_value,
  output hcb_pkg::req_t             head,
  output logic                      head_valid,
  input  logic                      take
);
  import hcb_pkg::*;

  req_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              acc;
  logic              deq;

  assign full       = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign acc        = push && !full;
  assign deq        = take && head_valid;
  assign head       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (acc) begin
      q[wr_ptr] <= '{op: op_t'(req_type), sym: byte_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (acc) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(acc) - (QPTR_W+1)'(deq);
    end
  end
endmodule

>>> design/hcb_sort.sv
// Sorted list of groups ordered by weight, with stable insertion and head removal.
module hcb_sort (
  input  logic                       clk,
  input  logic                       rst,
  input  hcb_pkg::sort_cmd_t         cmd,
  output logic [hcb_pkg::SYM_W-1:0]  head0_id,
  output logic [hcb_pkg::SYM_W-1:0]  head1_id,
  output logic [hcb_pkg::WGT_W-1:0]  head0_w,
  output logic [hcb_pkg::WGT_W-1:0]  head1_w,
  output logic [hcb_pkg::DIST_W-1:0] count
);
  import hcb_pkg::*;

  logic [WGT_W-1:0] lw [SYM_N];
  logic [SYM_W-1:0] lid [SYM_N];
  logic [SYM_N-1:0] gt;
  logic [SYM_N-1:0] prev_gt;
  logic [WGT_W-1:0] prev_w [SYM_N];
  logic [SYM_W-1:0] prev_id [SYM_N];
  logic [WGT_W-1:0] pop_w [SYM_N];
  logic [SYM_W-1:0] pop_id [SYM_N];

  assign head0_id = lid[0];
  assign head1_id = lid[1];
  assign head0_w  = lw[0];
  assign head1_w  = lw[1];

  for (genvar i = 0; i < SYM_N; i++) begin : g_cell
    assign gt[i] = (DIST_W'(i) >= count) || (lw[i] > cmd.w);
    if (i == 0) begin : g_first
      assign prev_gt[i] = 1'b0;
      assign prev_w[i]  = cmd.w;
      assign prev_id[i] = cmd.id;
    end else begin : g_rest
      assign prev_gt[i] = gt[i-1];
      assign prev_w[i]  = lw[i-1];
      assign prev_id[i] = lid[i-1];
    end
    if (i + 2 < SYM_N) begin : g_pop
      assign pop_w[i]  = lw[i+2];
      assign pop_id[i] = lid[i+2];
    end else begin : g_tail
      assign pop_w[i]  = lw[i];
      assign pop_id[i] = lid[i];
    end

    always_ff @(posedge clk) begin
      unique case (cmd.op)
        SORT_INS: begin
          if (gt[i]) begin
            lw[i]  <= prev_gt[i] ? prev_w[i] : cmd.w;
            lid[i] <= prev_gt[i] ? prev_id[i] : cmd.id;
          end
        end
        SORT_POP2: begin
          lw[i]  <= pop_w[i];
          lid[i] <= pop_id[i];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (cmd.op)
        SORT_CLR:  count <= '0;
        SORT_INS:  count <= count + 1'b1;
        SORT_POP2: count <= count - DIST_W'(2);
        default:   count <= count;
      endcase
    end
  end
endmodule

>>> design/hcb_back.sv
// Execution engine: histogram, code construction, code storage and result register.
module hcb_back (
  input  logic                        clk,
  input  logic                        rst,
  input  hcb_pkg::req_t               head,
  input  logic                        head_valid,
  output logic                        take,
  output hcb_pkg::sort_cmd_t          sort_cmd,
  input  logic [hcb_pkg::SYM_W-1:0]   head0_id,
  input  logic [hcb_pkg::SYM_W-1:0]   head1_id,
  input  logic [hcb_pkg::WGT_W-1:0]   head0_w,
  input  logic [hcb_pkg::WGT_W-1:0]   head1_w,
  input  logic [hcb_pkg::DIST_W-1:0]  sort_count,
  input  logic                        pop,
  output logic                        empty,
  output logic                        result_kind,
  output logic [hcb_pkg::DIST_W-1:0]  distinct_symbols,
  output logic                        symbol_present,
  output logic [hcb_pkg::LEN_W-1:0]   code_length,
  output logic [hcb_pkg::WORD_W-1:0]  code_word
);
  import hcb_pkg::*;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]  hist_mem [SYM_N];
  logic [SYM_W:0]    grp_mem [SYM_N];
  logic [LEN_W-1:0]  len_mem [SYM_N];
  logic [WORD_W-1:0] word_mem [SYM_N];
  logic [SYM_N-1:0]  hv;

  logic [DIST_W-1:0] s;
  logic [SYM_W-1:0]  sp;
  logic [SYM_W-1:0]  qsym;
  logic [SYM_W-1:0]  a_id;
  logic [SYM_W-1:0]  b_id;
  logic [WGT_W-1:0]  mw;
  logic [DIST_W-1:0] distinct;
  logic              merged;
  logic              built;
  logic              ovalid;
  logic              slot_free;

  logic              hist_re;
  logic [SYM_W-1:0]  hist_raddr;
  logic [CNT_W-1:0]  hist_q;
  logic              hvq;
  logic              hist_we;
  logic [CNT_W-1:0]  hist_cur;
  logic [CNT_W-1:0]  hist_wdata;
  logic              hv_clr;
  logic              present;

  logic              cw_re;
  logic [SYM_W-1:0]  cw_raddr;
  logic [SYM_W:0]    grp_q;
  logic [LEN_W-1:0]  len_q;
  logic [WORD_W-1:0] word_q;
  logic              cw_we;
  logic [SYM_W-1:0]  cw_waddr;
  logic [SYM_W:0]    grp_wdata;
  logic [LEN_W-1:0]  len_wdata;
  logic [WORD_W-1:0] word_wdata;
  logic              push_en;
  logic              push_bit;

  logic              load_build;
  logic              load_query;
  logic              q_present;

  assign sp        = SYM_W'(s - 1'b1);
  assign slot_free = !ovalid || pop;
  assign empty     = !ovalid;
  assign hist_cur  = hvq ? hist_q : '0;
  assign present   = hist_cur != '0;
  assign q_present = built && (len_q != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (head_valid) begin
          unique case (head.op)
            OP_ADD:  state_next = ST_ADD_WR;
            OP_QRY:  state_next = ST_QRY_RSP;
            OP_BLD:  state_next = ST_LOAD;
            OP_CLR:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD_WR:  state_next = ST_IDLE;
      ST_QRY_RSP: if (slot_free) state_next = ST_IDLE;
      ST_LOAD:    if (s == DIST_W'(SYM_N)) state_next = ST_CHECK;
      ST_CHECK:   state_next = (sort_count >= DIST_W'(2)) ? ST_POP : ST_FINISH;
      ST_POP:     state_next = ST_SWEEP;
      ST_SWEEP:   if (s == DIST_W'(SYM_N)) state_next = ST_INS;
      ST_INS:     state_next = ST_CHECK;
      ST_FINISH:  if (slot_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    take       = 1'b0;
    sort_cmd   = '{op: SORT_NOP, id: '0, w: '0};
    hist_re    = 1'b0;
    hist_raddr = head.sym;
    hist_we    = 1'b0;
    hist_wdata = (&hist_cur) ? hist_cur : hist_cur + 1'b1;
    hv_clr     = 1'b0;
    cw_re      = 1'b0;
    cw_raddr   = head.sym;
    cw_we      = 1'b0;
    cw_waddr   = sp;
    grp_wdata  = grp_q;
    len_wdata  = len_q;
    word_wdata = word_q;
    push_en    = 1'b0;
    push_bit   = 1'b0;
    load_build = 1'b0;
    load_query = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (head_valid) begin
          take = 1'b1;
          unique case (head.op)
            OP_ADD:  hist_re = 1'b1;
            OP_QRY:  cw_re = 1'b1;
            OP_CLR:  hv_clr = 1'b1;
            OP_BLD:  begin
              sort_cmd.op = SORT_CLR;
              hist_re     = 1'b1;
              hist_raddr  = '0;
            end
          endcase
        end
      end
      ST_ADD_WR: hist_we = 1'b1;
      ST_QRY_RSP: load_query = slot_free;
      ST_LOAD: begin
        if (s < DIST_W'(SYM_N)) begin
          hist_re    = 1'b1;
          hist_raddr = s[SYM_W-1:0];
        end
        if (s != '0) begin
          cw_we      = 1'b1;
          grp_wdata  = {!present, sp};
          len_wdata  = '0;
          word_wdata = '0;
          if (present) begin
            sort_cmd = '{op: SORT_INS, id: sp, w: WGT_W'(hist_cur)};
          end
        end
      end
      ST_CHECK: begin
        if (sort_count == DIST_W'(1) && !merged) begin
          cw_we      = 1'b1;
          cw_waddr   = head0_id;
          grp_wdata  = {1'b0, head0_id};
          len_wdata  = LEN_W'(1);
          word_wdata = '0;
        end
      end
      ST_POP: sort_cmd.op = SORT_POP2;
      ST_SWEEP: begin
        if (s < DIST_W'(SYM_N)) begin
          cw_re    = 1'b1;
          cw_raddr = s[SYM_W-1:0];
        end
        if (s != '0) begin
          if (grp_q == {1'b0, a_id}) begin
            cw_we   = 1'b1;
            push_en = 1'b1;
          end else if (grp_q == {1'b0, b_id}) begin
            cw_we     = 1'b1;
            push_en   = 1'b1;
            push_bit  = 1'b1;
            grp_wdata = {1'b0, a_id};
          end
          if (push_en && len_q < LEN_W'(MAX_LEN)) begin
            len_wdata  = len_q + 1'b1;
            word_wdata = word_q | (WORD_W'(push_bit) << len_q[LEN_W-2:0]);
          end
        end
      end
      ST_INS: sort_cmd = '{op: SORT_INS, id: a_id, w: mw};
      ST_FINISH: load_build = slot_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      hv     <= '0;
      built  <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (hv_clr) begin
        hv <= '0;
      end else if (hist_we) begin
        hv[qsym] <= 1'b1;
      end
      if (state == ST_LOAD) begin
        built <= 1'b1;
      end
      if (load_build || load_query) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hist_re) begin
      hist_q <= hist_mem[hist_raddr];
      hvq    <= hv[hist_raddr];
    end
    if (hist_we) begin
      hist_mem[qsym] <= hist_wdata;
    end
    if (cw_re) begin
      grp_q  <= grp_mem[cw_raddr];
      len_q  <= len_mem[cw_raddr];
      word_q <= word_mem[cw_raddr];
    end
    if (cw_we) begin
      grp_mem[cw_waddr]  <= grp_wdata;
      len_mem[cw_waddr]  <= len_wdata;
      word_mem[cw_waddr] <= word_wdata;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        qsym   <= head.sym;
        s      <= '0;
        merged <= 1'b0;
      end
      ST_LOAD: begin
        s <= s + 1'b1;
        if (s == DIST_W'(SYM_N)) begin
          distinct <= sort_count + DIST_W'(sort_cmd.op == SORT_INS);
        end
      end
      ST_POP: begin
        a_id   <= head0_id;
        b_id   <= head1_id;
        mw     <= head0_w + head1_w;
        merged <= 1'b1;
        s      <= '0;
      end
      ST_SWEEP: s <= s + 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_build) begin
      result_kind      <= KIND_BUILD;
      distinct_symbols <= distinct;
      symbol_present   <= 1'b0;
      code_length      <= '0;
      code_word        <= '0;
    end else if (load_query) begin
      result_kind      <= KIND_QUERY;
      distinct_symbols <= '0;
      symbol_present   <= q_present;
      code_length      <= q_present ? len_q : '0;
      code_word        <= q_present ? word_q : '0;
    end
  end
endmodule

>>> design/huffman_code_builder_unit.sv
// Top level of the Huffman code builder.
// Usage:
// Requests enter as beats on a queue interface: req_type and byte_value are
// taken when push is high and full is low. Four beats fit in the request queue.
// Add-byte beats update the histogram and a clear empties it; neither
// produces a result. A query produces one result beat after it reaches the
// head of the queue.
// A build reads all 256 histogram entries, then runs one merge per pair of
// groups; each merge sweeps every symbol.
// Results leave through a one-entry output register: the oldest result is on
// the ports while empty is low and is taken when pop is high.
// While a result waits, add and clear beats keep being executed; the next
// query or build holds at its last step until the register is free.
// Reset clears the histogram, the request queue and the output register, and
// queries answer absent until the first build.
`include "huffman_code_builder_unit_macros.svh"
module huffman_code_builder_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  req_type,
  input  logic [hcb_pkg::SYM_W-1:0]   byte_value,
  output logic                        empty,
  input  logic                        pop,
  output logic                        result_kind,
  output logic [hcb_pkg::DIST_W-1:0]  distinct_symbols,
  output logic                        symbol_present,
  output logic [hcb_pkg::LEN_W-1:0]   code_length,
  output logic [hcb_pkg::WORD_W-1:0]  code_word
);
  import hcb_pkg::*;

  req_t              head;
  logic              head_valid;
  logic              take;
  sort_cmd_t         sort_cmd;
  logic [SYM_W-1:0]  head0_id;
  logic [SYM_W-1:0]  head1_id;
  logic [WGT_W-1:0]  head0_w;
  logic [WGT_W-1:0]  head1_w;
  logic [DIST_W-1:0] sort_count;

  hcb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .byte_value (byte_value),
    .head       (head),
    .head_valid (head_valid),
    .take       (take)
  );

  hcb_sort u_sort (
    .clk      (clk),
    .rst      (rst),
    .cmd      (sort_cmd),
    .head0_id (head0_id),
    .head1_id (head1_id),
    .head0_w  (head0_w),
    .head1_w  (head1_w),
    .count    (sort_count)
  );

  hcb_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .head_valid       (head_valid),
    .take             (take),
    .sort_cmd         (sort_cmd),
    .head0_id         (head0_id),
    .head1_id         (head1_id),
    .head0_w          (head0_w),
    .head1_w          (head1_w),
    .sort_count       (sort_count),
    .pop              (pop),
    .empty            (empty),
    .result_kind      (result_kind),
    .distinct_symbols (distinct_symbols),
    .symbol_present   (symbol_present),
    .code_length      (code_length),
    .code_word        (code_word)
  );

  `HCB_ASSERT_IMP(a_build_no_code, clk, rst, !empty && result_kind == KIND_BUILD,
                  !symbol_present && code_length == '0 && code_word == '0)
  `HCB_ASSERT_IMP(a_query_no_count, clk, rst, !empty && result_kind == KIND_QUERY,
                  distinct_symbols == '0)
  `HCB_ASSERT_IMP(a_present_len, clk, rst, !empty && symbol_present,
                  code_length != '0 && code_length <= LEN_W'(MAX_LEN))
  `HCB_ASSERT_NEXT(a_result_kept, clk, rst, !empty && !pop, !empty)
endmodule
